// ===== src/rtd_pkg.sv =====
package rtd_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF = 28;

	// intermediates live in a signed range of [-2^62, 2^62-1]
	localparam int MID_W = 63;

	localparam int IDX_W = 3;

	typedef enum logic [IDX_W-1:0] {
		REG_K1 = 3'd0,
		REG_K2 = 3'd1,
		REG_K3 = 3'd2,
		REG_P1 = 3'd3,
		REG_P2 = 3'd4
	} reg_idx_t;

	typedef logic signed [MID_W-1:0] mid_t;

	localparam int MUL_LAT = 6;

	// pipeline stage map
	localparam int S_IN   = 1;
	localparam int S_SQ   = S_IN + MUL_LAT;
	localparam int S_R2   = S_SQ + 1;
	localparam int S_SUM  = S_R2 + 1;
	localparam int S_R4   = S_R2 + MUL_LAT;
	localparam int S_RAD1 = S_R4 + 1;
	localparam int S_R6   = S_R4 + MUL_LAT;
	localparam int S_RAD2 = S_R6 + 1;
	localparam int S_K3   = S_R6 + MUL_LAT;
	localparam int S_RAD  = S_K3 + 1;
	localparam int S_PRD  = S_RAD + MUL_LAT;
	localparam int S_D1   = S_PRD + 1;
	localparam int S_D2   = S_D1 + 1;
	localparam int S_OUT  = S_D2 + 1;

	localparam int PIPE_LAT = S_OUT;

endpackage

// ===== src/radial_tangential_distort_unit.sv =====
// radial-tangential lens distortion, five coefficients, fixed point
//
// input channel: point_valid / point_stall with point_x, point_y
// output channel: dist_valid / dist_stall with dist_x, dist_y, overflow
// config channel: cfg_valid / cfg_ready, cfg_index selects k1, k2, k3, p1, p2
// (indices 0 to 4, others ignored), cfg_data is the new coefficient; cfg_ready
// is always high, and writes belong in periods with no words in flight
//
// one point enters per cycle and one result leaves per cycle unless a result
// is held under dist_stall; a word passes five chained multiplier rounds, with
// the saturating adds between them and the output clamp after the last
//
// all stages advance together; while a result waits under dist_stall the whole
// pipeline holds and point_stall is high, so nothing is lost or repeated
//
// reset clears every stage's valid bit and sets all coefficients to zero,
// which makes the block pass points through unchanged
module radial_tangential_distort_unit #(
	parameter int COORD_WIDTH = rtd_pkg::COORD_WIDTH_DEF,
	parameter int FRAC_BITS = rtd_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          point_valid,
	output logic                          point_stall,
	input  logic signed [COORD_WIDTH-1:0] point_x,
	input  logic signed [COORD_WIDTH-1:0] point_y,
	output logic                          dist_valid,
	input  logic                          dist_stall,
	output logic signed [COORD_WIDTH-1:0] dist_x,
	output logic signed [COORD_WIDTH-1:0] dist_y,
	output logic                          overflow,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rtd_pkg::IDX_W-1:0]     cfg_index,
	input  logic [COORD_WIDTH-1:0]        cfg_data
);
	import rtd_pkg::*;

	localparam int EXT_W = MID_W - COORD_WIDTH;
	localparam mid_t ONE_FX = mid_t'(1) << FRAC_BITS;

	typedef struct packed {
		mid_t val;
		logic sat;
	} sat_mid_t;

	typedef struct packed {
		logic [COORD_WIDTH-1:0] val;
		logic                   sat;
	} out_sat_t;

	function automatic mid_t sext(input logic [COORD_WIDTH-1:0] v);
		return {{EXT_W{v[COORD_WIDTH-1]}}, v};
	endfunction

	function automatic sat_mid_t add_sat(input mid_t a, input mid_t b);
		logic [MID_W:0] sum;
		sat_mid_t r;
		sum = {a[MID_W-1], a} + {b[MID_W-1], b};
		r.sat = sum[MID_W] ^ sum[MID_W-1];
		r.val = r.sat ? {sum[MID_W], {(MID_W-1){~sum[MID_W]}}} : sum[MID_W-1:0];
		return r;
	endfunction

	function automatic out_sat_t out_clamp(input mid_t v);
		out_sat_t r;
		r.sat = (v[MID_W-1:COORD_WIDTH-1] != {(EXT_W+1){1'b0}})
			&& (v[MID_W-1:COORD_WIDTH-1] != {(EXT_W+1){1'b1}});
		r.val = r.sat ? {v[MID_W-1], {(COORD_WIDTH-1){~v[MID_W-1]}}} : v[COORD_WIDTH-1:0];
		return r;
	endfunction

	// coefficient registers
	logic [COORD_WIDTH-1:0] k1_q, k2_q, k3_q, p1_q, p2_q;
	mid_t k1_m, k2_m, k3_m, p1_m, p2_m;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k1_q <= '0;
			k2_q <= '0;
			k3_q <= '0;
			p1_q <= '0;
			p2_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_K1: k1_q <= cfg_data;
				REG_K2: k2_q <= cfg_data;
				REG_K3: k3_q <= cfg_data;
				REG_P1: p1_q <= cfg_data;
				REG_P2: p2_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign k1_m = sext(k1_q);
	assign k2_m = sext(k2_q);
	assign k3_m = sext(k3_q);
	assign p1_m = sext(p1_q);
	assign p2_m = sext(p2_q);

	// global advance
	logic adv;
	logic [S_D2:S_IN] vld_s;

	assign adv = !(dist_valid && dist_stall);
	assign point_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
			dist_valid <= 1'b0;
		end else if (adv) begin
			vld_s <= {vld_s[S_D2-1:S_IN], point_valid};
			dist_valid <= vld_s[S_D2];
		end
	end

	// datapath registers
	mid_t x_s [S_IN:S_RAD];
	mid_t y_s [S_IN:S_RAD];
	mid_t r2_s [S_R2:S_R4];
	mid_t txy_s [S_R2:S_RAD];
	mid_t sx_s [S_SUM:S_RAD];
	mid_t sy_s [S_SUM:S_RAD];
	mid_t rad1_s [S_RAD1:S_R6];
	mid_t rad2_s [S_RAD2:S_K3];
	mid_t tx2_s8, ty2_s8, rad_s27;
	mid_t dx1_s34, dy1_s34, p2sx_s34, p2txy_s34;
	mid_t dx_s35, dy_s35;
	logic [S_D2:S_R2] ovf_s, flag_in;

	// multiplier results
	mid_t x2_m, y2_m, xy_m, r4_m, k1r2_m, r6_m, k2r4_m, k3r6_m;
	mid_t xrad_m, yrad_m, p1txy_m, p2txy_m, p2sx_m, p1sy_m;
	logic x2_ov, y2_ov, xy_ov, r4_ov, k1r2_ov, r6_ov, k2r4_ov, k3r6_ov;
	logic xrad_ov, yrad_ov, p1txy_ov, p2txy_ov, p2sx_ov, p1sy_ov;

	rtd_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_x2 (
		.clk(clk), .en(adv), .a(x_s[S_IN]), .b(x_s[S_IN]), .prod(x2_m), .ovf(x2_ov)
	);
	rtd_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_y2 (
		.clk(clk), .en(adv), .a(y_s[S_IN]), .b(y_s[S_IN]), .prod(y2_m), .ovf(y2_ov)
	);
	rtd_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_xy (
		.clk(clk), .en(adv), .a(x_s[S_IN]), .b(y_s[S_IN]), .prod(xy_m), .ovf(xy_ov)
	);
	rtd_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_r4 (
		.clk(clk), .en(adv), .a(r2_s[S_R2]), .b(r2_s[S_R2]), .prod(r4_m), .ovf(r4_ov)
	);
	rtd_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_k1r2 (
		.clk(clk), .en(adv), .a(k1_m), .b(r2_s[S_R2]), .prod(k1r2_m), .ovf(k1r2_ov)
	);
	rtd_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_r6 (
		.clk(clk), .en(adv), .a(r4_m), .b(r2_s[S_R4]), .prod(r6_m), .ovf(r6_ov)
	);
	rtd_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_k2r4 (
		.clk(clk), .en(adv), .a(k2_m), .b(r4_m), .prod(k2r4_m), .ovf(k2r4_ov)
	);
	rtd_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_k3r6 (
		.clk(clk), .en(adv), .a(k3_m), .b(r6_m), .prod(k3r6_m), .ovf(k3r6_ov)
	);
	rtd_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_xrad (
		.clk(clk), .en(adv), .a(x_s[S_RAD]), .b(rad_s27), .prod(xrad_m), .ovf(xrad_ov)
	);
	rtd_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_yrad (
		.clk(clk), .en(adv), .a(y_s[S_RAD]), .b(rad_s27), .prod(yrad_m), .ovf(yrad_ov)
	);
	rtd_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_p1txy (
		.clk(clk), .en(adv), .a(p1_m), .b(txy_s[S_RAD]), .prod(p1txy_m), .ovf(p1txy_ov)
	);
	rtd_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_p2txy (
		.clk(clk), .en(adv), .a(p2_m), .b(txy_s[S_RAD]), .prod(p2txy_m), .ovf(p2txy_ov)
	);
	rtd_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_p2sx (
		.clk(clk), .en(adv), .a(p2_m), .b(sx_s[S_RAD]), .prod(p2sx_m), .ovf(p2sx_ov)
	);
	rtd_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_p1sy (
		.clk(clk), .en(adv), .a(p1_m), .b(sy_s[S_RAD]), .prod(p1sy_m), .ovf(p1sy_ov)
	);

	// saturating adds between the multiplier rounds
	sat_mid_t r2_a, txy_a, tx2_a, ty2_a, sx_a, sy_a;
	sat_mid_t rad1_a, rad2_a, rad_a, dx1_a, dy1_a, dx_a, dy_a;
	out_sat_t ox, oy;

	always_comb begin
		r2_a = add_sat(x2_m, y2_m);
		txy_a = add_sat(xy_m, xy_m);
		tx2_a = add_sat(x2_m, x2_m);
		ty2_a = add_sat(y2_m, y2_m);
		sx_a = add_sat(r2_s[S_R2], tx2_s8);
		sy_a = add_sat(r2_s[S_R2], ty2_s8);
		rad1_a = add_sat(ONE_FX, k1r2_m);
		rad2_a = add_sat(rad1_s[S_R6], k2r4_m);
		rad_a = add_sat(rad2_s[S_K3], k3r6_m);
		dx1_a = add_sat(xrad_m, p1txy_m);
		dy1_a = add_sat(yrad_m, p1sy_m);
		dx_a = add_sat(dx1_s34, p2sx_s34);
		dy_a = add_sat(dy1_s34, p2txy_s34);
		ox = out_clamp(dx_s35);
		oy = out_clamp(dy_s35);
	end

	// saturation seen, gathered per stage
	always_comb begin
		flag_in = '0;
		flag_in[S_R2] = x2_ov | y2_ov | xy_ov | r2_a.sat | txy_a.sat | tx2_a.sat | ty2_a.sat;
		flag_in[S_SUM] = sx_a.sat | sy_a.sat;
		flag_in[S_RAD1] = r4_ov | k1r2_ov | rad1_a.sat;
		flag_in[S_RAD2] = r6_ov | k2r4_ov | rad2_a.sat;
		flag_in[S_RAD] = k3r6_ov | rad_a.sat;
		flag_in[S_D1] = xrad_ov | yrad_ov | p1txy_ov | p2txy_ov | p2sx_ov | p1sy_ov
			| dx1_a.sat | dy1_a.sat;
		flag_in[S_D2] = dx_a.sat | dy_a.sat;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s[S_IN] <= sext(point_x);
			y_s[S_IN] <= sext(point_y);
			for (int i = S_IN + 1; i <= S_RAD; i++) begin
				x_s[i] <= x_s[i-1];
				y_s[i] <= y_s[i-1];
			end

			r2_s[S_R2] <= r2_a.val;
			for (int i = S_R2 + 1; i <= S_R4; i++) begin
				r2_s[i] <= r2_s[i-1];
			end

			txy_s[S_R2] <= txy_a.val;
			for (int i = S_R2 + 1; i <= S_RAD; i++) begin
				txy_s[i] <= txy_s[i-1];
			end
			tx2_s8 <= tx2_a.val;
			ty2_s8 <= ty2_a.val;

			sx_s[S_SUM] <= sx_a.val;
			sy_s[S_SUM] <= sy_a.val;
			for (int i = S_SUM + 1; i <= S_RAD; i++) begin
				sx_s[i] <= sx_s[i-1];
				sy_s[i] <= sy_s[i-1];
			end

			rad1_s[S_RAD1] <= rad1_a.val;
			for (int i = S_RAD1 + 1; i <= S_R6; i++) begin
				rad1_s[i] <= rad1_s[i-1];
			end

			rad2_s[S_RAD2] <= rad2_a.val;
			for (int i = S_RAD2 + 1; i <= S_K3; i++) begin
				rad2_s[i] <= rad2_s[i-1];
			end

			rad_s27 <= rad_a.val;

			dx1_s34 <= dx1_a.val;
			dy1_s34 <= dy1_a.val;
			p2sx_s34 <= p2sx_m;
			p2txy_s34 <= p2txy_m;

			dx_s35 <= dx_a.val;
			dy_s35 <= dy_a.val;

			ovf_s <= {ovf_s[S_D2-1:S_R2], 1'b0} | flag_in;

			dist_x <= ox.val;
			dist_y <= oy.val;
			overflow <= ovf_s[S_D2] | ox.sat | oy.sat;
		end
	end

endmodule

// ===== src/rtd_mul.sv =====
module rtd_mul #(
	parameter int FRAC_BITS = rtd_pkg::FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         en,
	input  rtd_pkg::mid_t a,
	input  rtd_pkg::mid_t b,
	output rtd_pkg::mid_t prod,
	output logic         ovf
);
	import rtd_pkg::*;

	localparam int LO_W = 32;
	localparam int HI_W = MID_W - LO_W;
	localparam int PP_W = LO_W + HI_W;
	localparam int PROD_W = 2 * MID_W;
	localparam int LOW_W = 2 * LO_W + 1;
	localparam int LO4_W = 2 * LO_W + 2;
	localparam int HS_W = PROD_W - 2 * LO_W;
	localparam logic [LOW_W-1:0] HALF = LOW_W'(1) << (FRAC_BITS - 1);
	localparam logic [MID_W-1:0] MAG_NEG = MID_W'(1) << (MID_W - 1);
	localparam logic [MID_W-1:0] MAG_POS = MAG_NEG - MID_W'(1);

	logic [MID_W-1:0]  ma_s1, mb_s1;
	logic              neg_s1, neg_s2, neg_s3, neg_s4, neg_s5;
	logic [2*LO_W-1:0] p00_s2;
	logic [PP_W-1:0]   p01_s2, p10_s2;
	logic [2*HI_W-1:0] p11_s2, p11_s3;
	logic [PP_W:0]     cross_s3;
	logic [LOW_W-1:0]  low_s3;
	logic [LO4_W-1:0]  lo_s4;
	logic [HS_W-1:0]   hi_s4;
	logic [MID_W-1:0]  mag_s5;
	logic              sat_s5;

	logic [PROD_W-1:0] full;
	logic [MID_W-1:0]  rnd, limit;
	logic              big;

	always_comb begin
		full = {hi_s4 + HS_W'(lo_s4[LO4_W-1:2*LO_W]), lo_s4[2*LO_W-1:0]};
		rnd = full[FRAC_BITS+MID_W-1:FRAC_BITS];
		limit = neg_s4 ? MAG_NEG : MAG_POS;
		big = (|full[PROD_W-1:FRAC_BITS+MID_W]) || (rnd > limit);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// magnitudes and sign
			ma_s1 <= a[MID_W-1] ? MID_W'(~a + 1'b1) : MID_W'(a);
			mb_s1 <= b[MID_W-1] ? MID_W'(~b + 1'b1) : MID_W'(b);
			neg_s1 <= a[MID_W-1] ^ b[MID_W-1];

			// partial products
			p00_s2 <= ma_s1[LO_W-1:0] * mb_s1[LO_W-1:0];
			p01_s2 <= ma_s1[LO_W-1:0] * mb_s1[MID_W-1:LO_W];
			p10_s2 <= ma_s1[MID_W-1:LO_W] * mb_s1[LO_W-1:0];
			p11_s2 <= ma_s1[MID_W-1:LO_W] * mb_s1[MID_W-1:LO_W];
			neg_s2 <= neg_s1;

			// cross terms, rounding constant
			cross_s3 <= {1'b0, p01_s2} + {1'b0, p10_s2};
			low_s3 <= {1'b0, p00_s2} + HALF;
			p11_s3 <= p11_s2;
			neg_s3 <= neg_s2;

			// low and high halves
			lo_s4 <= LO4_W'(low_s3) + LO4_W'({cross_s3[LO_W-1:0], {LO_W{1'b0}}});
			hi_s4 <= HS_W'(p11_s3) + HS_W'(cross_s3[PP_W:LO_W]);
			neg_s4 <= neg_s3;

			// carry join, shift and clamp
			mag_s5 <= big ? limit : rnd;
			sat_s5 <= big;
			neg_s5 <= neg_s4;

			prod <= neg_s5 ? mid_t'(~mag_s5 + 1'b1) : mid_t'(mag_s5);
			ovf <= sat_s5;
		end
	end

endmodule

// ===== src/rtd_checker.sv =====
module rtd_checker #(
	parameter int COORD_WIDTH = rtd_pkg::COORD_WIDTH_DEF
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   point_valid,
	input logic                   point_stall,
	input logic                   dist_valid,
	input logic                   dist_stall,
	input logic [COORD_WIDTH-1:0] dist_x,
	input logic [COORD_WIDTH-1:0] dist_y,
	input logic                   overflow
);
	import rtd_pkg::*;

	localparam int CNT_W = $clog2(PIPE_LAT + 1);

	// advancing cycles since the last accepted word
	logic [CNT_W-1:0] drain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_q <= CNT_W'(PIPE_LAT);
		end else if (point_valid && !point_stall) begin
			drain_q <= '0;
		end else if (!point_stall && (drain_q < CNT_W'(PIPE_LAT))) begin
			drain_q <= drain_q + 1'b1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dist_valid && dist_stall |=> dist_valid && $stable(dist_x) && $stable(dist_y)
			&& $stable(overflow))
		else $error("result word changed while stalled");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		point_stall |-> dist_valid && dist_stall)
		else $error("input stalled without a stalled result");

	a_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(drain_q >= CNT_W'(PIPE_LAT)) |-> !dist_valid)
		else $error("result word with no word in flight");

endmodule

bind radial_tangential_distort_unit rtd_checker #(.COORD_WIDTH(COORD_WIDTH)) u_rtd_checker (
	.clk(clk),
	.arst_n(arst_n),
	.point_valid(point_valid),
	.point_stall(point_stall),
	.dist_valid(dist_valid),
	.dist_stall(dist_stall),
	.dist_x(dist_x),
	.dist_y(dist_y),
	.overflow(overflow)
);
